// ===== rtl/price_level_order_book_unit_macros.svh =====
// assertion macros for the order book checker
`ifndef PRICE_LEVEL_ORDER_BOOK_UNIT_MACROS_SVH
`define PRICE_LEVEL_ORDER_BOOK_UNIT_MACROS_SVH

// same-cycle implication
`define PLOB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("order book check failed");

// next-cycle implication
`define PLOB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("order book check failed");

`endif

// ===== rtl/plob_pkg.sv =====
package plob_pkg;

  localparam logic [1:0] OP_UPDATE   = 2'd0;
  localparam logic [1:0] OP_SNAPSHOT = 2'd1;
  localparam logic [1:0] OP_METRICS  = 2'd2;

  localparam logic [2:0] ST_INSERTED    = 3'd0;
  localparam logic [2:0] ST_OVERWRITTEN = 3'd1;
  localparam logic [2:0] ST_REMOVED     = 3'd2;
  localparam logic [2:0] ST_ABSENT      = 3'd3;
  localparam logic [2:0] ST_FULL        = 3'd4;
  localparam logic [2:0] ST_QUERY       = 3'd5;

  localparam logic [2:0] MODE_HOLD = 3'd0;
  localparam logic [2:0] MODE_CMP  = 3'd1;
  localparam logic [2:0] MODE_INS  = 3'd2;
  localparam logic [2:0] MODE_OVR  = 3'd3;
  localparam logic [2:0] MODE_REM  = 3'd4;
  localparam logic [2:0] MODE_ROT  = 3'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic        bid;
    logic [31:0] key_price;
    logic [30:0] key_qty;
  } cell_ctrl_t;

endpackage

// ===== rtl/plob_cell.sv =====
module plob_cell (
  input  logic                clk,
  input  plob_pkg::cell_ctrl_t ctrl,
  input  logic                valid,
  input  logic                prev_ahead,
  input  logic [31:0]         prev_price,
  input  logic [30:0]         prev_qty,
  input  logic [31:0]         next_price,
  input  logic [30:0]         next_qty,
  output logic                ahead,
  output logic                eq,
  output logic [31:0]         price,
  output logic [30:0]         qty
);
  import plob_pkg::*;

  always_ff @(posedge clk) begin
    unique case (ctrl.mode)
      MODE_CMP: begin
        ahead <= valid && (ctrl.bid ? (price > ctrl.key_price) : (price < ctrl.key_price));
        eq    <= valid && (price == ctrl.key_price);
      end
      MODE_INS: begin
        if (!ahead) begin
          if (prev_ahead) begin
            price <= ctrl.key_price;
            qty   <= ctrl.key_qty;
          end else begin
            price <= prev_price;
            qty   <= prev_qty;
          end
        end
      end
      MODE_OVR: begin
        if (eq) qty <= ctrl.key_qty;
      end
      MODE_REM: begin
        if (!ahead) begin
          price <= next_price;
          qty   <= next_qty;
        end
      end
      MODE_ROT: begin
        price <= next_price;
        qty   <= next_qty;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/plob_chain.sv =====
module plob_chain #(
  parameter int DEPTH = 256,
  parameter int CW    = 9
) (
  input  logic                clk,
  input  plob_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       count,
  output logic                found,
  output logic [31:0]         head_price,
  output logic [30:0]         head_qty
);
  import plob_pkg::*;

  logic [31:0]    pr [DEPTH];
  logic [30:0]    qt [DEPTH];
  logic [DEPTH-1:0] bf;
  logic [DEPTH-1:0] eqv;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic        pb;
    logic [31:0] pp;
    logic [30:0] pq;
    logic        vld;
    if (i == 0) begin : g_first
      assign pb = 1'b1;
      assign pp = ctrl.key_price;
      assign pq = ctrl.key_qty;
    end else begin : g_rest
      assign pb = bf[i-1];
      assign pp = pr[i-1];
      assign pq = qt[i-1];
    end
    assign vld = (CW'(i) < count);
    plob_cell u_cell (
      .clk(clk), .ctrl(ctrl), .valid(vld), .prev_ahead(pb),
      .prev_price(pp), .prev_qty(pq),
      .next_price(pr[(i + 1) % DEPTH]), .next_qty(qt[(i + 1) % DEPTH]),
      .ahead(bf[i]), .eq(eqv[i]), .price(pr[i]), .qty(qt[i])
    );
  end

  assign found      = |eqv;
  assign head_price = pr[0];
  assign head_qty   = qt[0];

endmodule

// ===== rtl/price_level_order_book_unit.sv =====
// Two sorted chains of level cells, bids best-first by descending price and
// asks by ascending price. One item at a time: an update first compares in the
// chain, then shifts or overwrites, and then every update, snapshot or metrics
// item makes one full rotation of both chains to find the largest quantity.
// A snapshot then walks its side once more, giving its first TOP_LEVELS levels
// as results, one result per cycle while the output is taken. The next item is
// taken only after the current one is done; the rotation sets the rate.
module price_level_order_book_unit #(
  parameter int LEVEL_DEPTH = 256,
  parameter int TOP_LEVELS  = 50
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  operation,
  input  logic        side,
  input  logic [31:0] price,
  input  logic [30:0] quantity,
  input  logic [31:0] sequence_req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [2:0]  status,
  output logic [31:0] level_price,
  output logic [30:0] level_quantity,
  output logic [31:0] last_sequence_out,
  output logic [30:0] largest_quantity,
  output logic        last
);
  import plob_pkg::*;

  localparam int CW   = $clog2(LEVEL_DEPTH + 1);
  localparam int KEND = (LEVEL_DEPTH > TOP_LEVELS) ? LEVEL_DEPTH : TOP_LEVELS;
  localparam int KW   = $clog2(KEND) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_MAX   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_SNAP  = 3'd5;

  logic [2:0]    state;
  logic [1:0]    op_r;
  logic          side_r;
  logic [31:0]   price_r;
  logic [30:0]   qty_r;
  logic [31:0]   recent_seq;
  logic [2:0]    st_r;
  logic [CW-1:0] bid_count;
  logic [CW-1:0] ask_count;
  logic [KW-1:0] k;
  logic [30:0]   mx;

  cell_ctrl_t    bid_ctrl, ask_ctrl;
  logic [2:0]    upd_mode, bid_mode, ask_mode;
  logic          bid_found, ask_found;
  logic [31:0]   bid_hp, ask_hp;
  logic [30:0]   bid_hq, ask_hq;

  logic          found, full, out_free, emit;
  logic [CW-1:0] sel_count;
  logic [30:0]   m1, m2;
  logic [31:0]   sel_hp;
  logic [30:0]   sel_hq;
  logic          snap_in;

  assign found     = side_r ? bid_found : ask_found;
  assign sel_count = side_r ? bid_count : ask_count;
  assign full      = (sel_count == CW'(LEVEL_DEPTH));
  assign sel_hp    = side_r ? bid_hp : ask_hp;
  assign sel_hq    = side_r ? bid_hq : ask_hq;
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);
  assign snap_in   = (k < KW'(LEVEL_DEPTH));
  assign emit      = out_free && ((state == S_EMIT) ||
                                  (state == S_SNAP && k < KW'(TOP_LEVELS)));

  always_comb begin
    if (qty_r == 31'd0) upd_mode = found ? MODE_REM : MODE_HOLD;
    else if (found)     upd_mode = MODE_OVR;
    else                upd_mode = full ? MODE_HOLD : MODE_INS;
  end

  always_comb begin
    bid_mode = MODE_HOLD;
    ask_mode = MODE_HOLD;
    unique case (state)
      S_CMP: begin
        if (side_r) bid_mode = MODE_CMP;
        else        ask_mode = MODE_CMP;
      end
      S_APPLY: begin
        if (side_r) bid_mode = upd_mode;
        else        ask_mode = upd_mode;
      end
      S_MAX: begin
        bid_mode = MODE_ROT;
        ask_mode = MODE_ROT;
      end
      S_SNAP: begin
        if (snap_in && (k >= KW'(TOP_LEVELS) || out_free)) begin
          if (side_r) bid_mode = MODE_ROT;
          else        ask_mode = MODE_ROT;
        end
      end
      default: begin
      end
    endcase
  end

  assign bid_ctrl = '{mode: bid_mode, bid: 1'b1, key_price: price_r, key_qty: qty_r};
  assign ask_ctrl = '{mode: ask_mode, bid: 1'b0, key_price: price_r, key_qty: qty_r};

  plob_chain #(.DEPTH(LEVEL_DEPTH), .CW(CW)) u_bid (
    .clk(clk), .ctrl(bid_ctrl), .count(bid_count), .found(bid_found),
    .head_price(bid_hp), .head_qty(bid_hq)
  );

  plob_chain #(.DEPTH(LEVEL_DEPTH), .CW(CW)) u_ask (
    .clk(clk), .ctrl(ask_ctrl), .count(ask_count), .found(ask_found),
    .head_price(ask_hp), .head_qty(ask_hq)
  );

  assign m1 = (k < KW'(bid_count) && bid_hq > mx) ? bid_hq : mx;
  assign m2 = (k < KW'(ask_count) && ask_hq > m1) ? ask_hq : m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bid_count  <= '0;
      ask_count  <= '0;
      recent_seq <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (emit)           rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_r    <= operation;
            side_r  <= side;
            price_r <= price;
            qty_r   <= quantity;
            k       <= '0;
            mx      <= 31'd1;
            st_r    <= ST_QUERY;
            if (operation == OP_UPDATE) begin
              recent_seq <= sequence_req;
              state      <= S_CMP;
            end else if (operation == OP_SNAPSHOT || operation == OP_METRICS) begin
              state <= S_MAX;
            end
          end
        end
        S_CMP: state <= S_APPLY;
        S_APPLY: begin
          if (qty_r == 31'd0) begin
            st_r <= found ? ST_REMOVED : ST_ABSENT;
          end else if (found) begin
            st_r <= ST_OVERWRITTEN;
          end else begin
            st_r <= full ? ST_FULL : ST_INSERTED;
          end
          if (upd_mode == MODE_REM) begin
            if (side_r) bid_count <= bid_count - 1'b1;
            else        ask_count <= ask_count - 1'b1;
          end else if (upd_mode == MODE_INS) begin
            if (side_r) bid_count <= bid_count + 1'b1;
            else        ask_count <= ask_count + 1'b1;
          end
          state <= S_MAX;
        end
        S_MAX: begin
          mx <= m2;
          if (k == KW'(LEVEL_DEPTH - 1)) begin
            k     <= '0;
            state <= (op_r == OP_SNAPSHOT) ? S_SNAP : S_EMIT;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            status            <= st_r;
            level_price       <= (op_r == OP_UPDATE) ? price_r : 32'd0;
            level_quantity    <= (op_r == OP_UPDATE) ? qty_r : 31'd0;
            last_sequence_out <= recent_seq;
            largest_quantity  <= mx;
            last              <= 1'b1;
            state             <= S_IDLE;
          end
        end
        S_SNAP: begin
          if (k >= KW'(TOP_LEVELS) || out_free) begin
            if (k < KW'(TOP_LEVELS)) begin
              status            <= ST_QUERY;
              level_price       <= (k < KW'(sel_count)) ? sel_hp : 32'd0;
              level_quantity    <= (k < KW'(sel_count)) ? sel_hq : 31'd0;
              last_sequence_out <= recent_seq;
              largest_quantity  <= mx;
              last              <= (k == KW'(TOP_LEVELS - 1));
            end
            if (k == KW'(KEND - 1)) state <= S_IDLE;
            else                    k <= k + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/plob_checker.sv =====
`include "price_level_order_book_unit_macros.svh"

module plob_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  status,
  input logic [30:0] largest_quantity,
  input logic        last
);
  import plob_pkg::*;

  // a stalled result holds
  `PLOB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(last))
  // update results are single items
  `PLOB_ASSERT_NOW(a_upd_last, rsp_valid && status != ST_QUERY, last)
  // floor on the largest quantity
  `PLOB_ASSERT_NOW(a_big_floor, rsp_valid, largest_quantity != 31'd0)
  // a waiting item stays offered
  `PLOB_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid)

endmodule

bind price_level_order_book_unit plob_checker u_plob_checker (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
  .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status),
  .largest_quantity(largest_quantity), .last(last)
);

// ===== verif/price_level_order_book_unit_tb.sv =====
`timescale 1ns / 1ps

module price_level_order_book_unit_tb;
  import plob_pkg::*;

  localparam int DEPTH = 256;
  localparam int TOP = 50;
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 20;

  typedef struct {
    logic [1:0]  op;
    logic        sd;
    logic [31:0] px;
    logic [30:0] qty;
    logic [31:0] seq;
  } order_t;

  typedef struct {
    logic [2:0]  st;
    logic [31:0] px;
    logic [30:0] qty;
    logic [31:0] seq;
    logic [30:0] big;
    logic        fin;
  } level_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  logic [1:0] operation = '0;
  logic side = 1'b0;
  logic [31:0] price = '0;
  logic [30:0] quantity = '0;
  logic [31:0] sequence_req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic [2:0] status;
  logic [31:0] level_price;
  logic [30:0] level_quantity;
  logic [31:0] last_sequence_out;
  logic [30:0] largest_quantity;
  logic last;

  price_level_order_book_unit dut (.*);

  always #1 clk = ~clk;

  order_t pending_orders[$];
  level_rsp_t expected_levels[$];
  order_t cur_order;

  logic [31:0] bid_px[DEPTH];
  logic [30:0] bid_qty[DEPTH];
  logic [31:0] ask_px[DEPTH];
  logic [30:0] ask_qty[DEPTH];
  int bid_n = 0;
  int ask_n = 0;
  logic [31:0] book_seq = '0;

  int cycle_count = 0;
  int error_count = 0;
  int accepted_orders = 0;
  int checked_levels = 0;
  int full_drops = 0;

  function automatic logic [30:0] book_largest();
    logic [30:0] m;
    m = 31'd1;
    for (int i = 0; i < bid_n; i++) if (bid_qty[i] > m) m = bid_qty[i];
    for (int i = 0; i < ask_n; i++) if (ask_qty[i] > m) m = ask_qty[i];
    return m;
  endfunction

  function automatic logic [2:0] book_update(logic bid, logic [31:0] px, logic [30:0] q);
    int n;
    int pos;
    logic found;
    n = bid ? bid_n : ask_n;
    pos = 0;
    while (pos < n && (bid ? (bid_px[pos] > px) : (ask_px[pos] < px))) pos++;
    found = pos < n && ((bid ? bid_px[pos] : ask_px[pos]) == px);
    if (q == 0) begin
      if (!found) return ST_ABSENT;
      for (int i = pos; i < n - 1; i++) begin
        if (bid) begin
          bid_px[i] = bid_px[i + 1];
          bid_qty[i] = bid_qty[i + 1];
        end else begin
          ask_px[i] = ask_px[i + 1];
          ask_qty[i] = ask_qty[i + 1];
        end
      end
      if (bid) bid_n--; else ask_n--;
      return ST_REMOVED;
    end
    if (found) begin
      if (bid) bid_qty[pos] = q; else ask_qty[pos] = q;
      return ST_OVERWRITTEN;
    end
    if (n >= DEPTH) return ST_FULL;
    for (int i = n; i > pos; i--) begin
      if (bid) begin
        bid_px[i] = bid_px[i - 1];
        bid_qty[i] = bid_qty[i - 1];
      end else begin
        ask_px[i] = ask_px[i - 1];
        ask_qty[i] = ask_qty[i - 1];
      end
    end
    if (bid) begin
      bid_px[pos] = px;
      bid_qty[pos] = q;
      bid_n++;
    end else begin
      ask_px[pos] = px;
      ask_qty[pos] = q;
      ask_n++;
    end
    return ST_INSERTED;
  endfunction

  task automatic predict_book(order_t o);
    level_rsp_t r;
    int n;
    if (o.op == OP_UPDATE) begin
      book_seq = o.seq;
      r.st = book_update(o.sd, o.px, o.qty);
      if (r.st == ST_FULL) full_drops++;
      r.px = o.px;
      r.qty = o.qty;
      r.seq = book_seq;
      r.big = book_largest();
      r.fin = 1'b1;
      expected_levels.push_back(r);
    end else if (o.op == OP_SNAPSHOT) begin
      n = o.sd ? bid_n : ask_n;
      for (int k = 0; k < TOP; k++) begin
        r.st = ST_QUERY;
        r.px = k < n ? (o.sd ? bid_px[k] : ask_px[k]) : '0;
        r.qty = k < n ? (o.sd ? bid_qty[k] : ask_qty[k]) : '0;
        r.seq = book_seq;
        r.big = book_largest();
        r.fin = k == TOP - 1;
        expected_levels.push_back(r);
      end
    end else if (o.op == OP_METRICS) begin
      r.st = ST_QUERY;
      r.px = '0;
      r.qty = '0;
      r.seq = book_seq;
      r.big = book_largest();
      r.fin = 1'b1;
      expected_levels.push_back(r);
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  function automatic logic calm_window();
    return cycle_count >= 15000 && cycle_count < 35000;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        predict_book(cur_order);
        accepted_orders++;
      end
      if (!req_valid || req_ready) begin
        if (pending_orders.size() > 0 && (calm_window() || $urandom_range(0, 99) >= 13)) begin
          cur_order = pending_orders.pop_front();
          operation <= cur_order.op;
          side <= cur_order.sd;
          price <= cur_order.px;
          quantity <= cur_order.qty;
          sequence_req <= cur_order.seq;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    level_rsp_t e;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_levels.size() == 0) begin
          $display("%0t: unexpected item, status %0d price %0h", $time, status, level_price);
          error_count++;
        end else begin
          e = expected_levels.pop_front();
          check_field("status", 32'(e.st), 32'(status));
          check_field("level_price", e.px, level_price);
          check_field("level_quantity", 32'(e.qty), 32'(level_quantity));
          check_field("last_sequence_out", e.seq, last_sequence_out);
          check_field("largest_quantity", 32'(e.big), 32'(largest_quantity));
          check_field("last", 32'(e.fin), 32'(last));
          checked_levels++;
        end
      end
      rsp_ready <= calm_window() || $urandom_range(0, 99) >= 13;
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_order(logic [1:0] op, logic sd, logic [31:0] px, logic [30:0] q,
                           logic [31:0] seq);
    order_t o;
    o.op = op;
    o.sd = sd;
    o.px = px;
    o.qty = q;
    o.seq = seq;
    pending_orders.push_back(o);
  endtask

  function automatic logic [31:0] pick_price();
    return $urandom_range(0, 99) < 70 ? 32'($urandom_range(100, 131)) : $urandom;
  endfunction

  initial begin
    int roll;
    // directed: empty book, extremes, every status but full, reserved opcode
    add_order(OP_METRICS, 1'b0, '0, '0, '0);
    add_order(OP_SNAPSHOT, 1'b1, '0, '0, '0);
    add_order(OP_UPDATE, 1'b1, 32'd500, 31'd0, 32'hffff_ffff);
    add_order(OP_UPDATE, 1'b1, 32'hffff_ffff, 31'h7fff_ffff, 32'd1);
    add_order(OP_UPDATE, 1'b1, 32'd0, 31'd1, 32'd2);
    add_order(OP_UPDATE, 1'b1, 32'd700, 31'd40, 32'd3);
    add_order(OP_UPDATE, 1'b0, 32'd0, 31'd5, 32'd4);
    add_order(OP_UPDATE, 1'b0, 32'hffff_ffff, 31'd9, 32'd5);
    add_order(OP_UPDATE, 1'b0, 32'd800, 31'h5555_5555, 32'haaaa_aaaa);
    add_order(OP_UPDATE, 1'b1, 32'd700, 31'h2aaa_aaaa, 32'h5555_5555);
    add_order(OP_RESERVED, 1'b1, 32'd700, 31'd0, 32'd77);
    add_order(OP_SNAPSHOT, 1'b1, '0, '0, '0);
    add_order(OP_SNAPSHOT, 1'b0, '0, '0, '0);
    add_order(OP_UPDATE, 1'b1, 32'hffff_ffff, 31'd0, 32'd6);
    add_order(OP_UPDATE, 1'b0, 32'd800, 31'd0, 32'd7);
    add_order(OP_UPDATE, 1'b0, 32'd801, 31'd0, 32'd8);
    add_order(OP_METRICS, 1'b1, '0, '0, '0);
    add_order(OP_SNAPSHOT, 1'b0, '0, '0, '0);
    for (int i = 0; i < 180; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 80)
        add_order(OP_UPDATE, 1'($urandom_range(0, 1)), pick_price(),
                  $urandom_range(0, 3) == 0 ? 31'd0 : 31'($urandom), $urandom);
      else if (roll < 86)
        add_order(OP_SNAPSHOT, 1'($urandom_range(0, 1)), $urandom, 31'($urandom), $urandom);
      else if (roll < 97)
        add_order(OP_METRICS, 1'($urandom_range(0, 1)), $urandom, 31'($urandom), $urandom);
      else
        add_order(OP_RESERVED, 1'($urandom_range(0, 1)), $urandom, 31'($urandom), $urandom);
    end
    add_order(OP_UPDATE, 1'b1, 32'h8000_0001, 31'd3, 32'd9);
    add_order(OP_SNAPSHOT, 1'b1, '0, '0, '0);
    add_order(OP_METRICS, 1'b0, '0, '0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (pending_orders.size() == 0 && !req_valid);
    wait (expected_levels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d orders accepted, %0d levels checked, %0d full-table drops",
             accepted_orders, checked_levels, full_drops);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
